// ===== sv/assert_macros.svh =====
// assertion helpers shared by the rtl files
// clocked on clock, quiet while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/tsdrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsdrt_pkg
// shared sizes, stage records and run formatting for the dirty-run tracker
// ----------------------------------------------------------------------------
package tsdrt_pkg;

   localparam int ROWS         = 12;
   localparam int COLS         = 27;
   localparam int STORE_DEPTH  = ROWS * COLS;
   localparam int ADDR_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   localparam int OUT_DEPTH    = 4;
   localparam int OUT_PTR_W    = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W    = $clog2(OUT_DEPTH + 1);

   localparam int REQ_TDATA_W  = 24;
   localparam int RSP_TDATA_W  = 56;

   localparam logic [7:0] CH_SPACE     = 8'd32;
   localparam logic [7:0] Y_STEP       = 8'd14;
   localparam logic [7:0] Y_RED_SPLIT  = 8'd128;
   localparam logic [7:0] Y_GREEN_PEAK = 8'd96;
   localparam logic [7:0] Y_BLUE_PEAK  = 8'd192;

   // one character request as held in the input register
   typedef struct packed {
      logic [3:0] row;
      logic [4:0] start_col;
      logic [7:0] ch;
      logic       first;
      logic       last;
   } req_item_type;

   // character after position tracking, between the two stages
   typedef struct packed {
      logic              first;
      logic              last;
      logic              bad;
      logic              process;
      logic              active;
      logic [3:0]        row;
      logic [4:0]        col;
      logic [7:0]        ch;
      logic [ADDR_W-1:0] addr;
   } stg_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } mem_rd_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } mem_wr_type;

   typedef struct packed {
      logic [3:0] run_row;
      logic [4:0] run_start;
      logic [4:0] run_length;
      logic [7:0] pixel_y;
      logic [7:0] pixel_x;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       bad_position;
   } rsp_item_type;

   function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
      abs_diff = (a > b) ? 8'(a - b) : 8'(b - a);
   endfunction

   function automatic rsp_item_type make_run(input logic [3:0] row,
                                             input logic [4:0] start,
                                             input logic [4:0] len);
      rsp_item_type r;
      logic [7:0]   y;
      y              = 8'({4'd0, row} * Y_STEP);
      r.run_row      = row;
      r.run_start    = start;
      r.run_length   = len;
      r.pixel_y      = y;
      r.pixel_x      = {start, 3'd0};
      // 255 - x is the complement for 8-bit x
      r.red          = (y > Y_RED_SPLIT) ? y : ~y;
      r.green        = ~abs_diff(y, Y_GREEN_PEAK);
      r.blue         = ~abs_diff(y, Y_BLUE_PEAK);
      r.bad_position = 1'b0;
      make_run       = r;
   endfunction

   function automatic rsp_item_type make_bad(input logic [3:0] row,
                                             input logic [4:0] col);
      rsp_item_type r;
      r              = '0;
      r.run_row      = row;
      r.run_start    = col;
      r.bad_position = 1'b1;
      make_bad       = r;
   endfunction

endpackage

// ===== sv/tsdrt_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsdrt_store
// shadow character memory, one write and one registered read port per cycle,
// swept to zero after reset
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tsdrt_store (
   input  logic                   clock,
   input  logic                   reset,
   input  tsdrt_pkg::mem_rd_type  rd,
   input  tsdrt_pkg::mem_wr_type  wr,
   output logic [7:0]             rd_data,
   output logic                   clear_done
);
   import tsdrt_pkg::*;

   logic [7:0]        mem [STORE_DEPTH];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] clr_addr_in;
   logic              clr_busy_ff;
   logic              clr_busy_in;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = ADDR_W'(clr_addr_ff + 1'b1);
         if (clr_addr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   // write port: clearing sweep first, then character updates
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_done = !clr_busy_ff;

   `ASSERT_IMPL(a_no_access_while_clearing, clr_busy_ff, !rd.en && !wr.en, "store accessed during clear")

endmodule

// ===== sv/tsdrt_pos.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsdrt_pos
// cursor tracking and store address for each character, first stage
// ----------------------------------------------------------------------------
module tsdrt_pos (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  tsdrt_pkg::req_item_type in_item,
   output tsdrt_pkg::mem_rd_type   rd,
   output logic                    stg_valid,
   output tsdrt_pkg::stg_type      stg
);
   import tsdrt_pkg::*;

   logic [3:0] cur_row_ff;
   logic [3:0] cur_row_in;
   logic [4:0] cur_col_ff;
   logic [4:0] cur_col_in;
   logic       dropping_ff;
   logic       dropping_in;
   logic       stg_valid_ff;
   stg_type    stg_ff;
   stg_type    stg_in;

   logic [3:0] row_eff;
   logic [4:0] col_eff;
   logic       bad;
   logic       drop_eff;

   always_comb begin
      bad      = in_item.first &&
                 (({1'b0, in_item.row} >= 5'(ROWS)) || (in_item.start_col >= 5'(COLS)));
      row_eff  = in_item.first ? in_item.row       : cur_row_ff;
      col_eff  = in_item.first ? in_item.start_col : cur_col_ff;
      drop_eff = in_item.first ? bad               : dropping_ff;

      stg_in.first   = in_item.first;
      stg_in.last    = in_item.last;
      stg_in.bad     = bad;
      stg_in.process = !drop_eff;
      stg_in.active  = !drop_eff && (col_eff < 5'(COLS));
      stg_in.row     = row_eff;
      stg_in.col     = col_eff;
      stg_in.ch      = in_item.ch;
      stg_in.addr    = ADDR_W'(ADDR_W'(row_eff) * ADDR_W'(COLS)) + ADDR_W'(col_eff);

      cur_row_in  = cur_row_ff;
      cur_col_in  = cur_col_ff;
      dropping_in = dropping_ff;
      if (in_valid) begin
         if (bad) begin
            dropping_in = 1'b1;
         end else begin
            cur_row_in  = row_eff;
            cur_col_in  = stg_in.active ? 5'(col_eff + 5'd1) : col_eff;
            dropping_in = drop_eff || in_item.last;
         end
      end

      rd.en   = in_valid && stg_in.active;
      rd.addr = stg_in.addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         dropping_ff  <= 1'b0;
         stg_valid_ff <= 1'b0;
      end else begin
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         dropping_ff  <= dropping_in;
         stg_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      stg_ff <= stg_in;
   end

   assign stg_valid = stg_valid_ff;
   assign stg       = stg_ff;

endmodule

// ===== sv/tsdrt_run.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsdrt_run
// compare with the shadow store, update the store and gather dirty runs
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tsdrt_run (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    stg_valid,
   input  tsdrt_pkg::stg_type      stg,
   input  logic [7:0]              rd_data,
   output tsdrt_pkg::mem_wr_type   wr,
   output logic                    push,
   output tsdrt_pkg::rsp_item_type push_item
);
   import tsdrt_pkg::*;

   logic              in_run_ff;
   logic              in_run_in;
   logic [4:0]        run_begin_ff;
   logic [4:0]        run_begin_in;
   logic              fwd_valid_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [7:0]        fwd_data_ff;

   logic [7:0]   old_ch;
   logic         same;
   logic         run_open;
   logic         emit;
   logic         wr_hit;
   logic [4:0]   col_next;
   rsp_item_type res;

   always_comb begin
      // last cycle's write has not reached the read data yet
      old_ch   = (fwd_valid_ff && (fwd_addr_ff == stg.addr)) ? fwd_data_ff : rd_data;
      same     = (stg.ch == old_ch) || ((stg.ch == CH_SPACE) && (old_ch == 8'd0));
      col_next = stg.active ? 5'(stg.col + 5'd1) : stg.col;
      run_open = in_run_ff && !stg.first;

      in_run_in    = run_open;
      run_begin_in = run_begin_ff;
      emit         = 1'b0;
      wr_hit       = 1'b0;
      res          = '0;

      if (stg.bad) begin
         emit      = 1'b1;
         res       = make_bad(stg.row, stg.col);
         in_run_in = 1'b0;
      end else if (stg.process) begin
         if (stg.active) begin
            if (same) begin
               if (run_open) begin
                  emit      = 1'b1;
                  res       = make_run(stg.row, run_begin_ff, 5'(stg.col - run_begin_ff));
                  in_run_in = 1'b0;
               end
            end else begin
               wr_hit = 1'b1;
               if (!run_open) begin
                  in_run_in    = 1'b1;
                  run_begin_in = stg.col;
               end
            end
         end
         // end of the write closes whatever is open
         if (stg.last) begin
            if (in_run_in) begin
               emit = 1'b1;
               res  = make_run(stg.row, run_begin_in, 5'(col_next - run_begin_in));
            end
            in_run_in = 1'b0;
         end
      end

      wr.en     = stg_valid && wr_hit;
      wr.addr   = stg.addr;
      wr.data   = stg.ch;
      push      = stg_valid && emit;
      push_item = res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_run_ff    <= 1'b0;
         run_begin_ff <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         if (stg_valid) begin
            in_run_ff    <= in_run_in;
            run_begin_ff <= run_begin_in;
         end
         fwd_valid_ff <= wr.en;
      end
   end

   always_ff @(posedge clock) begin
      fwd_addr_ff <= wr.addr;
      fwd_data_ff <= wr.data;
   end

   `ASSERT_NEXT(a_report_closes_run, push && !push_item.bad_position, !in_run_ff, "run left open")
   `ASSERT_IMPL(a_no_write_on_bad, push && push_item.bad_position, !wr.en, "bad start written")

endmodule

// ===== sv/tsdrt_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsdrt_fifo
// small result queue that decouples the pipeline from the response side
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tsdrt_fifo (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  tsdrt_pkg::rsp_item_type          push_item,
   input  logic                             pop,
   output logic                             out_valid,
   output tsdrt_pkg::rsp_item_type          out_item,
   output logic [tsdrt_pkg::OUT_CNT_W-1:0]  count
);
   import tsdrt_pkg::*;

   rsp_item_type         entries_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wr_ptr_ff;
   logic [OUT_PTR_W-1:0] wr_ptr_in;
   logic [OUT_PTR_W-1:0] rd_ptr_ff;
   logic [OUT_PTR_W-1:0] rd_ptr_in;
   logic [OUT_CNT_W-1:0] count_ff;
   logic [OUT_CNT_W-1:0] count_in;
   logic                 do_pop;

   always_comb begin
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : OUT_PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : OUT_PTR_W'(rd_ptr_ff + 1'b1);
      end
      count_in = OUT_CNT_W'(count_ff + OUT_CNT_W'(push) - OUT_CNT_W'(do_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_item  = entries_ff[rd_ptr_ff];
   assign count     = count_ff;

   `ASSERT_IMPL(a_no_overflow, count_ff == OUT_CNT_W'(OUT_DEPTH), !push || do_pop, "result queue overflow")

endmodule

// ===== sv/text_screen_dirty_run_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_screen_dirty_run_tracker
// shadow text store with dirty-run detection for a character display
// ----------------------------------------------------------------------------
// usage
//   req_* carries one character per request: row and start column (used on
//   the request marked first in tuser), the character, and tlast on the
//   final character of a write. rsp_* reports one changed run per request
//   at most: row, start column, length, pixel origin and colour, or a bad
//   position report with tuser set.
// timing
//   one request per cycle sustained while rsp_tready is high. a result is
//   pushed into the output queue after the input and cursor stage registers.
//   the store is a single memory with one read and one write a cycle; a
//   write in one cycle is forwarded to the following character.
// reset
//   after reset the shadow store is swept to zero, one entry a cycle, over
//   all 324 entries; req_tready stays low until the sweep is done.
// stalls
//   a four-entry result queue absorbs rsp_tready low; req_tready drops only
//   once the queue plus the requests in flight could fill it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module text_screen_dirty_run_tracker (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tsdrt_pkg::REQ_TDATA_W-1:0]   req_tdata,  // row, start_col, ch
   input  logic                                req_tuser,  // first
   input  logic                                req_tlast,  // last
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tsdrt_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // run_row, run_start, run_length,
                                                           // pixel_y, pixel_x, red, green, blue
   output logic                                rsp_tuser   // bad_position
);
   import tsdrt_pkg::*;

   localparam int CRED_W = OUT_CNT_W + 1;

   // input register
   logic         in_valid_ff;
   req_item_type in_item_ff;
   req_item_type in_item_in;
   logic         req_take;

   // pipeline links
   mem_rd_type           rd;
   mem_wr_type           wr;
   logic [7:0]           rd_data;
   logic                 clear_done;
   logic                 stg_valid;
   stg_type              stg;
   logic                 push;
   rsp_item_type         push_item;
   rsp_item_type         out_item;
   logic [OUT_CNT_W-1:0] fifo_count;
   logic [CRED_W-1:0]    reserved;

   // every request in flight holds a queue slot until it reaches the queue
   assign reserved   = CRED_W'(fifo_count) + CRED_W'(in_valid_ff) + CRED_W'(stg_valid);
   assign req_tready = clear_done && (reserved < CRED_W'(OUT_DEPTH));
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_item_in.row       = req_tdata[3:0];
      in_item_in.start_col = req_tdata[8:4];
      in_item_in.ch        = req_tdata[16:9];
      in_item_in.first     = req_tuser;
      in_item_in.last      = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= in_item_in;
      end
   end

   // cursor and address stage
   tsdrt_pos u_pos (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_item   (in_item_ff),
      .rd        (rd),
      .stg_valid (stg_valid),
      .stg       (stg)
   );

   // shadow character store
   tsdrt_store u_store (
      .clock      (clock),
      .reset      (reset),
      .rd         (rd),
      .wr         (wr),
      .rd_data    (rd_data),
      .clear_done (clear_done)
   );

   // compare and run gathering stage
   tsdrt_run u_run (
      .clock     (clock),
      .reset     (reset),
      .stg_valid (stg_valid),
      .stg       (stg),
      .rd_data   (rd_data),
      .wr        (wr),
      .push      (push),
      .push_item (push_item)
   );

   // result queue
   tsdrt_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_item  (out_item),
      .count     (fifo_count)
   );

   assign rsp_tdata = {2'b00,
                       out_item.blue,
                       out_item.green,
                       out_item.red,
                       out_item.pixel_x,
                       out_item.pixel_y,
                       out_item.run_length,
                       out_item.run_start,
                       out_item.run_row};
   assign rsp_tuser = out_item.bad_position;

   `ASSERT_IMPL(a_credit_bound, 1'b1, reserved <= CRED_W'(OUT_DEPTH), "requests in flight exceed queue room")

endmodule

// ===== dv/text_screen_dirty_run_tracker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_screen_dirty_run_tracker_tb
// self-checking bench for the shadow text store and its dirty-run reports
// ----------------------------------------------------------------------------
// character requests go in one at a time through req_*. a local copy of the
// shadow store follows every accepted request and queues the run report it
// should cause. every report taken from rsp_* is checked field by field
// against the oldest one queued. directed corner cases come first, then
// random writes under several mixes of sender gaps and receiver stalls, a
// long receiver hold-off that backs the block up, and a full drain pause.
// ----------------------------------------------------------------------------
module text_screen_dirty_run_tracker_tb;

   import tsdrt_pkg::*;

   localparam int   HOLD_CYCLES = 200;   // long receiver hold-off
   localparam int   SETTLE      = 10;    // quiet cycles after the last report
   localparam int   ROW_PITCH   = 14;    // pixels per text row
   localparam int   COL_PITCH   = 8;     // pixels per text column
   localparam int   RED_FOLD    = 128;
   localparam int   GREEN_PEAK  = 96;
   localparam int   BLUE_PEAK   = 192;
   localparam int   FULL_LEVEL  = 255;
   localparam logic [7:0] SPACE = 8'd32;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;

   // local copy of the block state
   logic [7:0] shadow [STORE_DEPTH];
   int         sh_row, sh_col, sh_run_begin;
   bit         sh_in_run, sh_dropping;

   rsp_item_type pending_runs[$];
   int           mismatches    = 0;
   int           chars_live    = 0;   // requests the block does not ignore
   int           runs_seen     = 0;
   int           bad_seen      = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           hold_kicks    = 0;   // bumped to start a receiver hold-off

   text_screen_dirty_run_tracker DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("FAIL text_screen_dirty_run_tracker");
      $finish;
   end

   // run report with pixel origin and the row-dependent colour
   function automatic rsp_item_type run_report(input int row, input int start, input int len);
      rsp_item_type r;
      int           y;
      r              = '0;
      y              = (row * ROW_PITCH) & 8'hFF;
      r.run_row      = 4'(row);
      r.run_start    = 5'(start);
      r.run_length   = 5'(len);
      r.pixel_y      = 8'(y);
      r.pixel_x      = 8'(start * COL_PITCH);
      // red folds back above the split, green and blue peak at their rows
      r.red          = 8'(FULL_LEVEL - ((y > RED_FOLD) ? FULL_LEVEL - y : y));
      r.green        = 8'(FULL_LEVEL - ((y > GREEN_PEAK) ? y - GREEN_PEAK : GREEN_PEAK - y));
      r.blue         = 8'(FULL_LEVEL - ((y > BLUE_PEAK) ? y - BLUE_PEAK : BLUE_PEAK - y));
      return r;
   endfunction

   // follows one accepted character, returns 1 when it closes a run or is a bad start
   function automatic bit track_char(input logic [3:0] row, input logic [4:0] col,
                                     input logic [7:0] ch, input bit first, input bit last,
                                     output rsp_item_type rep);
      int         idx;
      logic [7:0] old;
      bit         same;
      bit         got;
      got = 1'b0;
      rep = '0;
      if (first) begin
         sh_in_run = 1'b0;
         if (row >= ROWS || col >= COLS) begin
            rep.run_row      = row;
            rep.run_start    = col;
            rep.bad_position = 1'b1;
            sh_dropping      = 1'b1;
            chars_live++;
            return 1'b1;
         end
         sh_row      = row;
         sh_col      = col;
         sh_dropping = 1'b0;
      end
      if (sh_dropping) return 1'b0;
      chars_live++;
      if (sh_col < COLS) begin
         idx  = sh_row * COLS + sh_col;
         old  = shadow[idx];
         // a space over an empty cell looks the same on screen
         same = (ch == old) || (ch == SPACE && old == 8'd0);
         if (same) begin
            if (sh_in_run) begin
               rep       = run_report(sh_row, sh_run_begin, sh_col - sh_run_begin);
               got       = 1'b1;
               sh_in_run = 1'b0;
            end
         end else begin
            shadow[idx] = ch;
            if (!sh_in_run) begin
               sh_in_run    = 1'b1;
               sh_run_begin = sh_col;
            end
         end
         sh_col++;
      end
      if (last) begin
         if (sh_in_run && !got) begin
            rep = run_report(sh_row, sh_run_begin, sh_col - sh_run_begin);
            got = 1'b1;
         end
         sh_in_run   = 1'b0;
         sh_dropping = 1'b1;
      end
      return got;
   endfunction

   // mix of repeats, a small alphabet and full-range codes
   function automatic logic [7:0] pick_char(input int row, input int col);
      logic [7:0] old;
      int         r;
      r = $urandom_range(99);
      if (col >= COLS) return 8'($urandom);
      old = shadow[row * COLS + col];
      if (r < 35) return (old == 8'd0 && $urandom_range(3) != 0) ? SPACE : old;
      if (r < 80) return 8'h41 + 8'($urandom_range(3));
      return 8'($urandom);
   endfunction

   // offers one request, returns once it has been taken
   task automatic put_char(input logic [3:0] row, input logic [4:0] col, input logic [7:0] ch,
                           input bit first, input bit last);
      rsp_item_type rep;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, ch, col, row};
      req_tuser  <= first;
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      if (track_char(row, col, ch, first, last, rep)) pending_runs.push_back(rep);
   endtask

   // sender stays quiet until every queued report has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_runs.size() != 0) @(posedge clock);
   endtask

   function automatic void check_field(input string name, input int want, input int seen);
      if (want != seen) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      end
   endfunction

   // result side: checks each report and decides rsp_tready for the next edge
   always @(posedge clock) begin : rsp_side
      rsp_item_type want;
      int           hold_seen;
      int           hold_left;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_runs.size() == 0) begin
            mismatches++;
            $display("%0t: report with nothing expected, actual tdata %h tuser %b",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want = pending_runs.pop_front();
            if (rsp_tuser) bad_seen++; else runs_seen++;
            check_field("run_row",      want.run_row,      rsp_tdata[3:0]);
            check_field("run_start",    want.run_start,    rsp_tdata[8:4]);
            check_field("run_length",   want.run_length,   rsp_tdata[13:9]);
            check_field("pixel_y",      want.pixel_y,      rsp_tdata[21:14]);
            check_field("pixel_x",      want.pixel_x,      rsp_tdata[29:22]);
            check_field("red",          want.red,          rsp_tdata[37:30]);
            check_field("green",        want.green,        rsp_tdata[45:38]);
            check_field("blue",         want.blue,         rsp_tdata[53:46]);
            check_field("bad_position", want.bad_position, rsp_tuser);
         end
      end
      if (hold_kicks != hold_seen) begin
         hold_seen = hold_kicks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // corner cases, each with its own short sequence of requests
   task automatic test_directed();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      // no first after reset: carries on at row 0, column 0
      put_char(4'd9, 5'd17, 8'h41, 1'b0, 1'b0);
      put_char(4'd0, 5'd0,  8'h42, 1'b0, 1'b1);
      // after the end mark, requests without first are ignored
      put_char(4'd0, 5'd0,  8'h43, 1'b0, 1'b0);
      // bad starts at the extremes, the tail of the write is dropped
      put_char(4'd15, 5'd31, 8'hFF, 1'b1, 1'b0);
      put_char(4'd0,  5'd0,  8'h44, 1'b0, 1'b1);
      put_char(4'd12, 5'd0,  8'h45, 1'b1, 1'b1);
      put_char(4'd0,  5'd27, 8'h46, 1'b1, 1'b1);
      // space over an empty cell and a zero code both count as unchanged
      put_char(4'd3, 5'd5, SPACE, 1'b1, 1'b0);
      put_char(4'd0, 5'd0, 8'h5A, 1'b0, 1'b0);
      put_char(4'd0, 5'd0, 8'h00, 1'b0, 1'b0);
      put_char(4'd0, 5'd0, 8'hFF, 1'b0, 1'b1);
      // writing off the right edge, the end mark still closes the run
      put_char(4'd11, 5'd25, 8'h61, 1'b1, 1'b0);
      put_char(4'd0,  5'd0,  8'h62, 1'b0, 1'b0);
      put_char(4'd0,  5'd0,  8'h63, 1'b0, 1'b0);
      put_char(4'd0,  5'd0,  8'h64, 1'b0, 1'b1);
      // unfinished write: the open run is discarded by the next first
      put_char(4'd5, 5'd0,  8'h71, 1'b1, 1'b0);
      put_char(4'd0, 5'd0,  8'h72, 1'b0, 1'b0);
      put_char(4'd5, 5'd10, 8'h01, 1'b1, 1'b1);
      // rewrite of what is already there gives no report
      put_char(4'd11, 5'd25, 8'h61, 1'b1, 1'b1);
      put_char(4'd0,  5'd0,  8'h41, 1'b1, 1'b1);
      // last cell of the top row
      put_char(4'd0, 5'd26, 8'h80, 1'b1, 1'b1);
      wait_drained();
   endtask

   // one random write, mostly well formed
   task automatic random_write();
      int         kind, len, i;
      logic [3:0] row;
      logic [4:0] col;
      kind = $urandom_range(99);
      row  = 4'($urandom_range(ROWS - 1));
      col  = 5'($urandom_range(COLS - 1));
      len  = ($urandom_range(7) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 8);
      if (kind < 80) begin
         for (i = 0; i < len; i++)
            put_char((i == 0) ? row : 4'($urandom), (i == 0) ? col : 5'($urandom),
                     pick_char(row, col + i), i == 0, i == len - 1);
      end else if (kind < 85) begin
         // bad start followed by a few dropped characters
         row = 4'($urandom);
         col = 5'($urandom);
         if (row < ROWS && col < COLS) col = 5'($urandom_range(COLS, 31));
         len = $urandom_range(1, 4);
         for (i = 0; i < len; i++)
            put_char((i == 0) ? row : 4'($urandom), (i == 0) ? col : 5'($urandom),
                     8'($urandom), i == 0, i == len - 1);
      end else if (kind < 90) begin
         // stray characters without a first mark
         len = $urandom_range(1, 3);
         for (i = 0; i < len; i++)
            put_char(4'($urandom), 5'($urandom), 8'($urandom), 1'b0, $urandom_range(1));
      end else if (kind < 95) begin
         // write left open, the next first cuts it off
         len = $urandom_range(1, 5);
         for (i = 0; i < len; i++)
            put_char((i == 0) ? row : 4'($urandom), (i == 0) ? col : 5'($urandom),
                     pick_char(row, col + i), i == 0, 1'b0);
      end else begin
         // single character anywhere in the field range
         put_char(4'($urandom), 5'($urandom), 8'($urandom), 1'b1, 1'b1);
      end
   endtask

   task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
      int target;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      target         = chars_live + count;
      while (chars_live < target) random_write();
      wait_drained();
   endtask

   // receiver holds off while alternating changed and unchanged cells
   // make a report every second character, so the result queue fills
   task automatic test_backpressure();
      int         w, c, idx;
      logic [3:0] row;
      logic [7:0] ch;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_kicks <= hold_kicks + 1;
      for (w = 0; w < 3; w++) begin
         row = 4'($urandom_range(ROWS - 1));
         for (c = 0; c < 14; c++) begin
            idx = row * COLS + c;
            if (c % 2 == 0) ch = (shadow[idx] == 8'h41) ? 8'h42 : 8'h41;
            else            ch = shadow[idx];
            put_char(row, 5'(c), ch, c == 0, c == 13);
         end
      end
      wait_drained();
   endtask

   initial begin
      foreach (shadow[i]) shadow[i] = 8'd0;
      sh_row       = 0;
      sh_col       = 0;
      sh_run_begin = 0;
      sh_in_run    = 1'b0;
      sh_dropping  = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);

      test_directed();
      test_random_phase(0, 0, 220);
      test_backpressure();
      test_random_phase(52, 0, 220);
      test_random_phase(0, 52, 220);
      test_random_phase(13, 13, 220);

      repeat (SETTLE) @(posedge clock);
      $display("covered %0d live characters giving %0d run reports and %0d bad starts",
               chars_live, runs_seen, bad_seen);
      $display("under sender gaps, receiver stalls and a %0d-cycle receiver hold-off",
               HOLD_CYCLES);
      if (mismatches == 0 && pending_runs.size() == 0) begin
         $display("PASS text_screen_dirty_run_tracker");
      end else begin
         $display("FAIL text_screen_dirty_run_tracker");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/tsdrt_pkg.sv
sv/tsdrt_store.sv
sv/tsdrt_pos.sv
sv/tsdrt_run.sv
sv/tsdrt_fifo.sv
sv/text_screen_dirty_run_tracker.sv
dv/text_screen_dirty_run_tracker_tb.sv
